// ===== sv/ptiba_pkg.sv =====
// ----------------------------------------------------------------------------
// ptiba_pkg: shared types and constants
// Field widths, buffer depths, configuration register codes and the
// filter coefficient bundle for the temporal bandpass amplifier.
// ----------------------------------------------------------------------------
package ptiba_pkg;

    // Default sizes of the coefficient store and of the pyramid
    localparam int unsigned MAX_COEFFS_DEF = 262144;
    localparam int unsigned MAX_LEVELS_DEF = 8;

    // Field widths
    localparam int unsigned COEFF_W    = 16;
    localparam int unsigned LEVEL_W    = 3;
    localparam int unsigned ADDR_W     = 18;
    localparam int unsigned COEF_W     = 15;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned GAINS_W    = 64;
    localparam int unsigned LCOUNT_W   = 4;
    localparam int unsigned STATE_W    = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    // Reset value of the level count register
    localparam logic [LCOUNT_W-1:0] LCOUNT_RESET = 4'd6;

    // Depths of the classify queue and of the result buffer
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned OUT_DEPTH   = 8;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_POLE,
        CFG_HIGH_SCALE,
        CFG_LOW_POLE,
        CFG_LOW_SCALE,
        CFG_GAINS_LOWER,
        CFG_GAINS_UPPER,
        CFG_LEVEL_COUNT
    } cfg_index_t;

    // Coefficients of the two first-order lowpass filters, unsigned Q0.15
    typedef struct packed {
        logic [COEF_W-1:0] high_pole;
        logic [COEF_W-1:0] high_scale;
        logic [COEF_W-1:0] low_pole;
        logic [COEF_W-1:0] low_scale;
    } filter_cfg_t;

endpackage

// ===== sv/pyramid_temporal_iir_bandpass_amp.sv =====
// ----------------------------------------------------------------------------
// pyramid_temporal_iir_bandpass_amp: temporal bandpass and amplification
// Per-address temporal bandpass of pyramid coefficients, the difference of two
// first-order lowpass filters, with per-level gain and 16-bit saturation.
// ----------------------------------------------------------------------------
// The block takes up to one pyramid coefficient per clock and returns one
// amplified band value per item, in order. Items pass a four-entry classify
// queue, a four-stage filter pipeline and an eight-entry result buffer. The
// filter state lives in one memory of MAX_COEFFS words of 64 bits (a power
// of two; addresses wrap onto it), written once and read once per cycle. A
// second item for the same address in direct succession is held in the
// queue while the first is in stage A of the state read-modify-write loop;
// otherwise one item per cycle is sustained while the result buffer has
// room. State entries are not cleared: every address must see a first frame
// item before it is filtered. The user must write registers only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pyramid_temporal_iir_bandpass_amp #(
    parameter int unsigned MAX_COEFFS = ptiba_pkg::MAX_COEFFS_DEF,
    parameter int unsigned MAX_LEVELS = ptiba_pkg::MAX_LEVELS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ptiba_pkg::COEFF_W-1:0]  s_coeff_in,
    input  logic [ptiba_pkg::LEVEL_W-1:0]         s_level,
    input  logic [ptiba_pkg::ADDR_W-1:0]          s_coeff_addr,
    input  logic                                  s_first_frame,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ptiba_pkg::COEFF_W-1:0]  m_band_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptiba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptiba_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ptiba_pkg::*;

    localparam int unsigned ENTRY_W = $clog2(MAX_COEFFS) + COEFF_W + GAIN_W + 1;

    filter_cfg_t           filt_reg;
    logic [GAINS_W-1:0]    gains_lower_reg;
    logic [GAINS_W-1:0]    gains_upper_reg;
    logic [LCOUNT_W-1:0]   level_count_reg;

    logic                  q_valid;
    logic                  q_pop;
    logic [ENTRY_W-1:0]    q_data;

    assign cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg        <= '0;
            gains_lower_reg <= '0;
            gains_upper_reg <= '0;
            level_count_reg <= LCOUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_HIGH_POLE:   filt_reg.high_pole  <= cfg_data[COEF_W-1:0];
                CFG_HIGH_SCALE:  filt_reg.high_scale <= cfg_data[COEF_W-1:0];
                CFG_LOW_POLE:    filt_reg.low_pole   <= cfg_data[COEF_W-1:0];
                CFG_LOW_SCALE:   filt_reg.low_scale  <= cfg_data[COEF_W-1:0];
                CFG_GAINS_LOWER: gains_lower_reg     <= cfg_data;
                CFG_GAINS_UPPER: gains_upper_reg     <= cfg_data;
                CFG_LEVEL_COUNT: level_count_reg     <= cfg_data[LCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    ptiba_front #(
        .MAX_COEFFS (MAX_COEFFS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coeff_in    (s_coeff_in),
        .s_level       (s_level),
        .s_coeff_addr  (s_coeff_addr),
        .s_first_frame (s_first_frame),
        .gains_lower   (gains_lower_reg),
        .gains_upper   (gains_upper_reg),
        .level_count   (level_count_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data)
    );

    ptiba_back #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (filt_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_band_out (m_band_out)
    );

endmodule

// ===== sv/ptiba_fifo.sv =====
// ----------------------------------------------------------------------------
// ptiba_fifo: small register FIFO
// First-word-fall-through queue used between the front and back ends and
// as the result buffer.
// ----------------------------------------------------------------------------
module ptiba_fifo #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = store[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/ptiba_front.sv =====
// ----------------------------------------------------------------------------
// ptiba_front: accept and classify
// Takes input items, resolves the store index and the level gain (zero on
// first frames, the finest level and the top levels) and queues them.
// ----------------------------------------------------------------------------
module ptiba_front #(
    parameter int unsigned MAX_COEFFS = ptiba_pkg::MAX_COEFFS_DEF,
    parameter int unsigned MAX_LEVELS = ptiba_pkg::MAX_LEVELS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ptiba_pkg::COEFF_W-1:0]  s_coeff_in,
    input  logic [ptiba_pkg::LEVEL_W-1:0]         s_level,
    input  logic [ptiba_pkg::ADDR_W-1:0]          s_coeff_addr,
    input  logic                                  s_first_frame,
    input  logic [ptiba_pkg::GAINS_W-1:0]         gains_lower,
    input  logic [ptiba_pkg::GAINS_W-1:0]         gains_upper,
    input  logic [ptiba_pkg::LCOUNT_W-1:0]        level_count,
    output logic                                  q_valid,
    input  logic                                  q_pop,
    output logic [$clog2(MAX_COEFFS)+ptiba_pkg::COEFF_W+ptiba_pkg::GAIN_W:0] q_data
);
    import ptiba_pkg::*;

    localparam int unsigned AW      = $clog2(MAX_COEFFS);
    localparam int unsigned ENTRY_W = AW + COEFF_W + GAIN_W + 1;

    logic [GAIN_W-1:0]  gain_sel;
    logic [GAIN_W-1:0]  gain;
    logic               zero_gain;
    logic [AW-1:0]      idx;
    logic [ENTRY_W-1:0] entry;
    logic               q_full;

    // Pick the level's gain from the two gain banks
    always_comb begin
        if (s_level[LEVEL_W-1]) begin
            gain_sel = gains_upper[GAIN_W * s_level[LEVEL_W-2:0] +: GAIN_W];
        end else begin
            gain_sel = gains_lower[GAIN_W * s_level[LEVEL_W-2:0] +: GAIN_W];
        end
    end

    // Force zero gain on first frames, the finest level and the top levels
    assign zero_gain = s_first_frame
                    || (s_level == '0)
                    || (({1'b0, s_level} + LCOUNT_W'(1)) >= level_count)
                    || (32'(s_level) >= MAX_LEVELS);
    assign gain  = zero_gain ? '0 : gain_sel;

    // Wrap the address onto the store
    assign idx   = AW'(s_coeff_addr);
    assign entry = {s_first_frame, gain, s_coeff_in, idx};

    assign s_ready = !q_full;

    ptiba_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

endmodule

// ===== sv/ptiba_back.sv =====
// ----------------------------------------------------------------------------
// ptiba_back: filter pipeline
// Reads the per-address state, runs both lowpass filters, writes the state
// back, scales the band by the gain and buffers the results.
// ----------------------------------------------------------------------------
module ptiba_back #(
    parameter int unsigned MAX_COEFFS = ptiba_pkg::MAX_COEFFS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ptiba_pkg::filter_cfg_t                cfg,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  logic [$clog2(MAX_COEFFS)+ptiba_pkg::COEFF_W+ptiba_pkg::GAIN_W:0] q_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ptiba_pkg::COEFF_W-1:0]  m_band_out
);
    import ptiba_pkg::*;

    localparam int unsigned AW     = $clog2(MAX_COEFFS);
    localparam int unsigned WORD_W = 2 * STATE_W + COEFF_W;
    localparam int unsigned CNT_W  = $clog2(OUT_DEPTH + 1);

    // Saturate a 26-bit value to the 24-bit state range
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [25:0] v);
        logic signed [STATE_W-1:0] r;
        if (v[25:23] == 3'b000 || v[25:23] == 3'b111) begin
            r = v[STATE_W-1:0];
        end else if (v[25]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Saturate a 30-bit value to the 16-bit result range
    function automatic logic signed [COEFF_W-1:0] sat_out(input logic signed [29:0] v);
        logic signed [COEFF_W-1:0] r;
        if ((v[29:15] == '0) || (v[29:15] == '1)) begin
            r = v[COEFF_W-1:0];
        end else if (v[29]) begin
            r = {1'b1, {(COEFF_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COEFF_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Queue head fields
    logic [AW-1:0]              h_idx;
    logic signed [COEFF_W-1:0]  h_sample;
    logic [GAIN_W-1:0]          h_gain;
    logic                       h_first;

    assign h_idx    = q_data[AW-1:0];
    assign h_sample = q_data[AW+COEFF_W-1:AW];
    assign h_gain   = q_data[AW+COEFF_W+GAIN_W-1:AW+COEFF_W];
    assign h_first  = q_data[AW+COEFF_W+GAIN_W];

    // State memory: {high lowpass, low lowpass, previous sample}
    logic [WORD_W-1:0] mem [MAX_COEFFS];
    logic [WORD_W-1:0] rd_reg;

    // Outstanding items between queue pop and result delivery
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_take;

    // Stage A: state read done, forward and multiply
    logic                      a_valid_reg;
    logic [AW-1:0]             a_idx_reg;
    logic signed [COEFF_W-1:0] a_sample_reg;
    logic [GAIN_W-1:0]         a_gain_reg;
    logic                      a_first_reg;

    // Stage B: sum, round, saturate, write back
    logic                      b_valid_reg;
    logic [AW-1:0]             b_idx_reg;
    logic signed [COEFF_W-1:0] b_sample_reg;
    logic [GAIN_W-1:0]         b_gain_reg;
    logic                      b_first_reg;
    logic signed [39:0]        b_hp_reg, b_lp_reg;
    logic signed [32:0]        b_hs_reg, b_ls_reg;

    // Stage C: band times gain
    logic                      c_valid_reg;
    logic [AW-1:0]             c_idx_reg;
    logic signed [STATE_W-1:0] c_hi_reg, c_lo_reg;
    logic signed [COEFF_W-1:0] c_sample_reg;
    logic [GAIN_W-1:0]         c_gain_reg;

    // Stage D: round and saturate the result
    logic                      d_valid_reg;
    logic signed [41:0]        d_prod_reg;

    // Hold the next item while the one ahead has the same index
    logic hazard;
    assign hazard = a_valid_reg && (a_idx_reg == h_idx);
    assign q_pop  = q_valid && (cnt_reg < CNT_W'(OUT_DEPTH)) && !hazard;

    // Stage A logic: take the newest state, from stage C when it matches
    logic                      fwd;
    logic signed [STATE_W-1:0] st_hi, st_lo;
    logic signed [COEFF_W-1:0] st_prev;
    logic signed [COEFF_W:0]   pair;
    logic signed [15:0]        hp_s, hs_s, lp_s, ls_s;
    logic signed [39:0]        a_hp, a_lp;
    logic signed [32:0]        a_hs, a_ls;

    assign fwd     = c_valid_reg && (c_idx_reg == a_idx_reg);
    assign st_hi   = fwd ? c_hi_reg     : rd_reg[WORD_W-1:WORD_W-STATE_W];
    assign st_lo   = fwd ? c_lo_reg     : rd_reg[COEFF_W+STATE_W-1:COEFF_W];
    assign st_prev = fwd ? c_sample_reg : rd_reg[COEFF_W-1:0];
    assign pair    = {a_sample_reg[COEFF_W-1], a_sample_reg} + {st_prev[COEFF_W-1], st_prev};

    assign hp_s = {1'b0, cfg.high_pole};
    assign hs_s = {1'b0, cfg.high_scale};
    assign lp_s = {1'b0, cfg.low_pole};
    assign ls_s = {1'b0, cfg.low_scale};
    assign a_hp = hp_s * st_hi;
    assign a_lp = lp_s * st_lo;
    assign a_hs = hs_s * pair;
    assign a_ls = ls_s * pair;

    // Stage B logic: accumulate in Q.23, round half up to Q.8
    logic signed [40:0]        acc_hi, acc_lo;
    logic signed [STATE_W-1:0] new_hi, new_lo, first_state;
    logic [WORD_W-1:0]         b_word;

    assign acc_hi = {b_hp_reg[39], b_hp_reg} + {{4{b_hs_reg[32]}}, b_hs_reg, 4'b0}
                  + 41'sd16384;
    assign acc_lo = {b_lp_reg[39], b_lp_reg} + {{4{b_ls_reg[32]}}, b_ls_reg, 4'b0}
                  + 41'sd16384;
    assign first_state = {{4{b_sample_reg[COEFF_W-1]}}, b_sample_reg, 4'b0};
    assign new_hi = b_first_reg ? first_state : sat_state(acc_hi[40:15]);
    assign new_lo = b_first_reg ? first_state : sat_state(acc_lo[40:15]);
    assign b_word = {new_hi, new_lo, b_sample_reg};

    // Stage C logic: difference of the lowpasses times the gain
    logic signed [STATE_W:0] diff;
    logic signed [16:0]      gain_s;
    logic signed [41:0]      c_prod;

    assign diff   = {c_hi_reg[STATE_W-1], c_hi_reg} - {c_lo_reg[STATE_W-1], c_lo_reg};
    assign gain_s = {1'b0, c_gain_reg};
    assign c_prod = diff * gain_s;

    // Stage D logic: round half up to Q.4 and saturate
    logic signed [41:0]        d_round;
    logic signed [COEFF_W-1:0] d_result;

    assign d_round  = d_prod_reg + 42'sd2048;
    assign d_result = sat_out(d_round[41:12]);

    // Write back the new state, read the state of the popped item
    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            mem[b_idx_reg] <= b_word;
        end
        if (q_pop) begin
            rd_reg <= mem[h_idx];
        end
    end

    // Advance stage valids and the outstanding count
    assign cnt_next = cnt_reg + CNT_W'(q_pop) - CNT_W'(out_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            a_valid_reg <= q_pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            cnt_reg     <= cnt_next;
        end
    end

    // Advance stage payloads
    always_ff @(posedge aclk) begin
        a_idx_reg    <= h_idx;
        a_sample_reg <= h_sample;
        a_gain_reg   <= h_gain;
        a_first_reg  <= h_first;

        b_idx_reg    <= a_idx_reg;
        b_sample_reg <= a_sample_reg;
        b_gain_reg   <= a_gain_reg;
        b_first_reg  <= a_first_reg;
        b_hp_reg     <= a_hp;
        b_hs_reg     <= a_hs;
        b_lp_reg     <= a_lp;
        b_ls_reg     <= a_ls;

        c_idx_reg    <= b_idx_reg;
        c_hi_reg     <= new_hi;
        c_lo_reg     <= new_lo;
        c_sample_reg <= b_sample_reg;
        c_gain_reg   <= b_gain_reg;

        d_prod_reg   <= c_prod;
    end

    // Result buffer, sized to the outstanding count so it never overflows
    logic out_full;
    logic [COEFF_W-1:0] out_data;

    assign out_take   = m_valid && m_ready;
    assign m_band_out = out_data;

    ptiba_fifo #(
        .WIDTH (COEFF_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (d_valid_reg),
        .push_data (d_result),
        .full      (out_full),
        .pop       (m_ready),
        .pop_data  (out_data),
        .not_empty (m_valid)
    );

`ifndef NO_ASSERTIONS
    // Outstanding count stays within the result buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(OUT_DEPTH))
        else $error("outstanding count exceeds result buffer depth");

    // Items in flight are all counted as outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg}) <= cnt_reg)
        else $error("pipeline holds more items than are outstanding");

    // Stages A and B never work on the same index
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && b_valid_reg) |-> (a_idx_reg != b_idx_reg))
        else $error("same index in stages A and B");

    // A finished item always finds room in the result buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg |-> !out_full)
        else $error("result buffer full on push");
`endif

endmodule
